FILE: src/clp_pkg.sv
// Shared types, codes and constants of the Content-Length header parser.
`timescale 1ns / 1ps

package clp_pkg;

  // Fixed field widths
  localparam int BYTE_W          = 8;
  localparam int CFG_W           = 20;
  localparam int LEN_OUT_W       = 20;
  localparam int STATUS_W        = 3;
  localparam int KPOS_W          = 4;

  // Defaults handed to the top-level parameters
  localparam int LENGTH_BITS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_W-1:0]  MAX_LENGTH_RESET = 20'd16384;
  localparam logic [KPOS_W-1:0] LONG_KEY_LEN     = 4'd14;
  localparam logic [KPOS_W-1:0] COMPACT_KEY_LEN  = 4'd1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NONDIGIT = 3'd3,
    ST_OVER     = 3'd4
  } status_t;

  // One classified message byte as it travels from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] ch;        // lowercased byte (A-Z only)
    logic              is_trim;   // space, tab, CR or LF
    logic              is_colon;
    logic              is_digit;
    logic              is_cr;
    logic              is_lf;
    logic              last;
  } clp_beat_t;

  // A held CR that turns out to be line content
  localparam clp_beat_t CR_BEAT = '{
    ch:       8'h0d,
    is_trim:  1'b1,
    is_colon: 1'b0,
    is_digit: 1'b0,
    is_cr:    1'b1,
    is_lf:    1'b0,
    last:     1'b0
  };

  // Letters of the long key, indexed by match position
  function automatic logic [BYTE_W-1:0] long_key_char(logic [KPOS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: src/clp_front.sv
// Front end: takes message bytes and classifies them into queue beats.
`timescale 1ns / 1ps

module clp_front
  import clp_pkg::*;
(
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] msg_byte,
  input  logic              last_byte,
  input  logic              q_full,
  output logic              q_push,
  output clp_beat_t         q_beat
);

  logic is_upper;

  // Accept a byte whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the byte and fold upper-case letters down
  assign is_upper = (msg_byte >= "A") && (msg_byte <= "Z");

  always_comb begin
    q_beat.ch       = is_upper ? (msg_byte | 8'h20) : msg_byte;
    q_beat.is_trim  = (msg_byte == " ") || (msg_byte == 8'h09) ||
                      (msg_byte == 8'h0d) || (msg_byte == 8'h0a);
    q_beat.is_colon = (msg_byte == ":");
    q_beat.is_digit = (msg_byte >= "0") && (msg_byte <= "9");
    q_beat.is_cr    = (msg_byte == 8'h0d);
    q_beat.is_lf    = (msg_byte == 8'h0a);
    q_beat.last     = last_byte;
  end

endmodule

FILE: src/clp_queue.sv
// Short beat queue between the classifying front and the parsing back.
`timescale 1ns / 1ps

module clp_queue
  import clp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  clp_beat_t push_beat,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output clp_beat_t head_beat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clp_beat_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_beat  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/clp_back.sv
// Back end: header line parser state and the per-message result register.
`timescale 1ns / 1ps

module clp_back
  import clp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [LENGTH_BITS-1:0] max_len,
  input  logic                   q_valid,
  input  clp_beat_t              q_beat,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   ok,
  output logic [STATUS_W-1:0]    status,
  output logic [LEN_OUT_W-1:0]   length,
  output logic                   header_seen
);

  localparam int WIDE_W = LENGTH_BITS + 4;

  typedef enum logic [2:0] {
    PH_KEY   = 3'b001,
    PH_VALUE = 3'b010,
    PH_SKIP  = 3'b100
  } line_phase_t;

  typedef enum logic [2:0] {
    VP_LEAD   = 3'b001,
    VP_DIGITS = 3'b010,
    VP_TRAIL  = 3'b100
  } value_phase_t;

  typedef struct packed {
    line_phase_t            lp;
    logic [KPOS_W-1:0]      kpos;
    logic                   started;
    logic                   trail;
    logic                   bad;
    logic                   compact;
    value_phase_t           vp;
    logic [LENGTH_BITS-1:0] accum;
    logic [LENGTH_BITS-1:0] committed;
    logic                   seen;
    status_t                err;
    logic                   done;
    logic                   pend_cr;
    logic                   prev_lb;
  } pstate_t;

  pstate_t st;
  pstate_t st_work;
  pstate_t st_next;
  logic    res_ok;
  status_t res_status;
  logic [LENGTH_BITS-1:0] res_length;
  logic    res_seen;

  function automatic logic halted(pstate_t s);
    return s.done || (s.err != ST_OK);
  endfunction

  function automatic pstate_t clear_line(pstate_t s);
    pstate_t r;
    r         = s;
    r.lp      = PH_KEY;
    r.kpos    = '0;
    r.started = 1'b0;
    r.trail   = 1'b0;
    r.bad     = 1'b0;
    r.compact = 1'b0;
    r.vp      = VP_LEAD;
    r.accum   = '0;
    return r;
  endfunction

  function automatic pstate_t clear_message(pstate_t s);
    pstate_t r;
    r           = clear_line(s);
    r.pend_cr   = 1'b0;
    r.prev_lb   = 1'b0;
    r.committed = '0;
    r.seen      = 1'b0;
    r.err       = ST_OK;
    r.done      = 1'b0;
    return r;
  endfunction

  function automatic pstate_t key_char(pstate_t s, clp_beat_t b);
    pstate_t r;
    logic    hit;
    r   = s;
    hit = s.started && !s.bad &&
          (s.compact ? (s.kpos == COMPACT_KEY_LEN) : (s.kpos == LONG_KEY_LEN));
    if (b.is_colon) begin
      if (!hit) begin
        r.lp = PH_SKIP;
      end else if (s.seen) begin
        r.err = ST_DUP;
      end else begin
        r.seen = 1'b1;
        r.lp   = PH_VALUE;
      end
    end else if (b.is_trim) begin
      if (s.started) begin
        r.trail = 1'b1;
      end
    end else if (s.trail || s.bad) begin
      r.bad = 1'b1;
    end else if (!s.started) begin
      r.started = 1'b1;
      if (b.ch == "l") begin
        r.compact = 1'b1;
        r.kpos    = COMPACT_KEY_LEN;
      end else if (b.ch == long_key_char('0)) begin
        r.kpos = 4'd1;
      end else begin
        r.bad = 1'b1;
      end
    end else if (!s.compact && (s.kpos < LONG_KEY_LEN) &&
                 (b.ch == long_key_char(s.kpos))) begin
      r.kpos = s.kpos + 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic pstate_t value_char(pstate_t s, clp_beat_t b,
                                         logic [LENGTH_BITS-1:0] maxl);
    pstate_t           r;
    logic [WIDE_W-1:0] nxt;
    r   = s;
    // ten times the value so far plus the digit, as shifts and adds
    nxt = WIDE_W'({s.accum, 3'b000}) + WIDE_W'({s.accum, 1'b0}) +
          WIDE_W'(b.ch[3:0]);
    if (b.is_trim) begin
      if (s.vp == VP_DIGITS) begin
        r.vp = VP_TRAIL;
      end
    end else if (b.is_digit && (s.vp != VP_TRAIL)) begin
      if (nxt > WIDE_W'(maxl)) begin
        r.err = ST_OVER;
      end else begin
        r.accum = nxt[LENGTH_BITS-1:0];
        r.vp    = VP_DIGITS;
      end
    end else begin
      r.err = ST_NONDIGIT;
    end
    return r;
  endfunction

  function automatic pstate_t line_char(pstate_t s, clp_beat_t b,
                                        logic [LENGTH_BITS-1:0] maxl);
    pstate_t r;
    r         = s;
    r.prev_lb = 1'b0;
    unique case (s.lp)
      PH_KEY:   r = key_char(r, b);
      PH_VALUE: r = value_char(r, b, maxl);
      PH_SKIP:  r = r;
      default:  r = r;
    endcase
    return r;
  endfunction

  function automatic pstate_t finish_line(pstate_t s);
    pstate_t r;
    r = s;
    if (s.lp == PH_VALUE) begin
      if (s.vp == VP_LEAD) begin
        r.err = ST_EMPTY;
      end else begin
        r.committed = s.accum;
      end
    end
    return clear_line(r);
  endfunction

  // Take a beat unless it ends a message while the result register is held
  assign q_pop = q_valid && !(q_beat.last && out_valid && out_stall);

  // Apply one byte, then close the message on its last byte
  always_comb begin
    st_work = st;
    if (!halted(st_work)) begin
      if (st_work.pend_cr && q_beat.is_lf) begin
        st_work.pend_cr = 1'b0;
        if (st_work.prev_lb) begin
          st_work.done = 1'b1;
        end else begin
          st_work         = finish_line(st_work);
          st_work.prev_lb = 1'b1;
        end
      end else begin
        if (st_work.pend_cr) begin
          st_work.pend_cr = 1'b0;
          st_work         = line_char(st_work, CR_BEAT, max_len);
        end
        if (!halted(st_work)) begin
          if (q_beat.is_cr) begin
            st_work.pend_cr = 1'b1;
          end else begin
            st_work = line_char(st_work, q_beat, max_len);
          end
        end
      end
    end
    if (q_beat.last && !halted(st_work)) begin
      if (st_work.pend_cr) begin
        st_work.pend_cr = 1'b0;
        st_work         = line_char(st_work, CR_BEAT, max_len);
      end
      if (!halted(st_work)) begin
        st_work = finish_line(st_work);
      end
    end
    res_ok     = (st_work.err == ST_OK);
    res_status = st_work.err;
    res_length = st_work.committed;
    res_seen   = st_work.seen;
    st_next    = q_beat.last ? clear_message(st_work) : st_work;
  end

  // Hold parser state between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= clear_message('0);
    end else if (q_pop) begin
      st <= st_next;
    end
  end

  // Drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_beat.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_beat.last) begin
      ok          <= res_ok;
      status      <= res_status;
      length      <= LEN_OUT_W'(res_length);
      header_seen <= res_seen;
    end
  end

`ifndef SYNTHESIS
  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (status == ST_OK)))
    else $error("ok flag disagrees with status");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.err != ST_OK && !(q_pop && q_beat.last)) |=> (st.err == $past(st.err)))
    else $error("error code changed within a message");

  a_no_length_without_header: assert property (@(posedge clk) disable iff (rst)
    !st.seen |-> (st.committed == '0))
    else $error("length committed without a matching header");

  a_key_pos_range: assert property (@(posedge clk) disable iff (rst)
    st.kpos <= LONG_KEY_LEN)
    else $error("key match position past end of key");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_beat.last && out_valid && out_stall) |-> !q_pop)
    else $error("final beat popped while result register is held");
`endif

endmodule

FILE: src/sip_content_length_parser.sv
// Top level of the SIP Content-Length header parser.
`timescale 1ns / 1ps

// Takes a SIP message one byte per beat, finds the Content-Length header
// (long or compact form) in the header section and returns one result per
// message, registered as the back end pops its last byte. One byte is
// accepted every clock cycle while the queue has room: the classifier
// feeds a two-entry queue and the parser back end retires one queued byte
// per cycle, its per-byte key/value update and multiply-by-ten accumulate
// being combinational. Only a result held by a stalled output stalls the
// final byte of the next message; earlier bytes keep flowing. max_length
// may be written at any idle time; its write channel is always ready.
module sip_content_length_parser
  import clp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     max_length,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    msg_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 ok,
  output logic [STATUS_W-1:0]  status,
  output logic [LEN_OUT_W-1:0] length,
  output logic                 header_seen
);

  logic [LENGTH_BITS-1:0] max_len;
  logic                   q_full;
  logic                   q_push;
  clp_beat_t              push_beat;
  logic                   q_pop;
  logic                   q_valid;
  clp_beat_t              head_beat;

  // Hold the length limit, masked to the accumulator width
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LENGTH_BITS'(MAX_LENGTH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      max_len <= LENGTH_BITS'(max_length);
    end
  end

  clp_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .msg_byte  (msg_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_beat    (push_beat)
  );

  clp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_beat  (push_beat),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_beat  (head_beat)
  );

  clp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .max_len     (max_len),
    .q_valid     (q_valid),
    .q_beat      (head_beat),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .status      (status),
    .length      (length),
    .header_seen (header_seen)
  );

endmodule

FILE: tb/content_length_checker.sv
// Checker for the Content-Length parser: predicts each message verdict and compares.
`timescale 1ns / 1ps

module content_length_checker
  import clp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_W-1:0]     max_length,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    msg_byte,
  input  logic                 last_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 ok,
  input  logic [STATUS_W-1:0]  status,
  input  logic [LEN_OUT_W-1:0] length,
  input  logic                 header_seen,
  output int                   mismatches,
  output int                   pending,
  output int                   verdicts
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam int         NAME_LEN = 14;
  localparam logic [8*NAME_LEN-1:0] LONG_NAME = "content-length";

  typedef enum logic [1:0] {LINE_KEY, LINE_VALUE, LINE_SKIP} line_phase_e;
  typedef enum logic [1:0] {VAL_LEAD, VAL_DIGITS, VAL_TRAIL} value_phase_e;

  typedef struct packed {
    logic                 ok;
    status_t              status;
    logic [LEN_OUT_W-1:0] length;
    logic                 seen;
  } verdict_t;

  // Parser state mirrored beat by beat
  logic [CFG_W-1:0]     limit;
  line_phase_e          line_phase;
  value_phase_e         val_phase;
  int                   key_pos;
  logic                 key_started, key_trail, key_bad, key_compact;
  logic                 cr_held, after_break;
  logic [31:0]          val_acc;
  logic [LEN_OUT_W-1:0] committed;
  logic                 seen, done;
  status_t              err;

  verdict_t verdict_q[$];
  verdict_t want;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [7:0] long_name_at(input int pos);
    return LONG_NAME[8*(NAME_LEN-1-pos) +: 8];
  endfunction

  function automatic void clear_line();
    line_phase  = LINE_KEY;
    key_pos     = 0;
    key_started = 1'b0;
    key_trail   = 1'b0;
    key_bad     = 1'b0;
    key_compact = 1'b0;
    val_phase   = VAL_LEAD;
    val_acc     = '0;
  endfunction

  function automatic void clear_message();
    clear_line();
    cr_held     = 1'b0;
    after_break = 1'b0;
    committed   = '0;
    seen        = 1'b0;
    err         = ST_OK;
    done        = 1'b0;
  endfunction

  function automatic logic halted();
    return done || err != ST_OK;
  endfunction

  // Match the key against the long and compact names, case-insensitive
  function automatic void key_byte(input logic [7:0] raw);
    logic [7:0] c;
    logic       hit;
    c = raw;
    if (c == CH_COLON) begin
      hit = key_started && !key_bad &&
            (key_compact ? key_pos == 1 : key_pos == NAME_LEN);
      if (!hit) begin
        line_phase = LINE_SKIP;
      end else if (seen) begin
        err = ST_DUP;
      end else begin
        seen       = 1'b1;
        line_phase = LINE_VALUE;
      end
    end else if (is_blank(c)) begin
      if (key_started) key_trail = 1'b1;
    end else begin
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      if (key_trail || key_bad) begin
        key_bad = 1'b1;
      end else if (!key_started) begin
        key_started = 1'b1;
        if (c == "l") begin
          key_compact = 1'b1;
          key_pos     = 1;
        end else if (c == long_name_at(0)) begin
          key_pos = 1;
        end else begin
          key_bad = 1'b1;
        end
      end else if (!key_compact && key_pos < NAME_LEN && c == long_name_at(key_pos)) begin
        key_pos = key_pos + 1;
      end else begin
        key_bad = 1'b1;
      end
    end
  endfunction

  // Accumulate decimal digits, reject anything else past the trimmed ends
  function automatic void value_byte(input logic [7:0] c);
    logic [31:0] nxt;
    if (is_blank(c)) begin
      if (val_phase == VAL_DIGITS) val_phase = VAL_TRAIL;
    end else if (c >= "0" && c <= "9" && val_phase != VAL_TRAIL) begin
      nxt = val_acc * 32'd10 + {24'd0, c} - 32'd48;
      if (nxt > {{(32-CFG_W){1'b0}}, limit}) begin
        err = ST_OVER;
      end else begin
        val_acc   = nxt;
        val_phase = VAL_DIGITS;
      end
    end else begin
      err = ST_NONDIGIT;
    end
  endfunction

  function automatic void line_byte(input logic [7:0] c);
    after_break = 1'b0;
    if (line_phase == LINE_KEY) key_byte(c);
    else if (line_phase == LINE_VALUE) value_byte(c);
  endfunction

  function automatic void end_line();
    if (line_phase == LINE_VALUE) begin
      if (val_phase == VAL_LEAD) err = ST_EMPTY;
      else committed = val_acc[LEN_OUT_W-1:0];
    end
    clear_line();
  endfunction

  // Advance the model by one message byte; queue a verdict on the last one
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    if (!halted()) begin
      if (cr_held && b == CH_LF) begin
        cr_held = 1'b0;
        if (after_break) begin
          done = 1'b1;
        end else begin
          end_line();
          after_break = 1'b1;
        end
      end else begin
        if (cr_held) begin
          cr_held = 1'b0;
          line_byte(CH_CR);
        end
        if (!halted()) begin
          if (b == CH_CR) cr_held = 1'b1;
          else line_byte(b);
        end
      end
    end
    if (last) begin
      // Close an unterminated last line, a held CR counting as content
      if (!halted()) begin
        if (cr_held) begin
          cr_held = 1'b0;
          line_byte(CH_CR);
        end
        if (!halted()) end_line();
      end
      v.ok     = (err == ST_OK);
      v.status = err;
      v.length = committed;
      v.seen   = seen;
      verdict_q.insert(verdict_q.size(), v);
      clear_message();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, got_val);
    end
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      limit = MAX_LENGTH_RESET;
      clear_message();
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit = max_length;
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got ok=%0b status=%0d",
                   $time, ok, status);
          $display("%0t:   length=%0d seen=%0b", $time, length, header_seen);
        end else begin
          want = verdict_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(ok));
          check_field("status", 32'(want.status), 32'(status));
          check_field("length", 32'(want.length), 32'(length));
          check_field("header_seen", 32'(want.seen), 32'(header_seen));
          verdicts++;
        end
      end
      if (in_valid && !in_stall) parse_byte(msg_byte, last_byte);
    end
    pending = verdict_q.size();
  end

endmodule

FILE: tb/tb_sip_content_length_parser.sv
// Testbench top for the SIP Content-Length parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sip_content_length_parser;
  import clp_pkg::*;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam int N_PHASES        = 8;
  localparam int PHASE_BYTES     = 144;
  localparam int PHASE_MSGS      = 6;
  localparam int SETTLE_CYCLES   = 8;
  localparam int IDLE_HEAVY      = 83;
  localparam int IDLE_LIGHT      = 17;
  localparam int MAX_LIMIT       = 1048575;
  localparam int MIN_LIMIT       = 9;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     max_length;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    msg_byte;
  logic                 last_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 ok;
  logic [STATUS_W-1:0]  status;
  logic [LEN_OUT_W-1:0] length;
  logic                 header_seen;

  int mismatches, pending, verdicts;
  int send_idle_pct, stall_pct;
  int cur_limit;
  int bytes_sent, msgs_sent, limit_writes;
  logic [7:0] msg_q[$];

  sip_content_length_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .max_length (max_length),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .msg_byte   (msg_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .status     (status),
    .length     (length),
    .header_seen(header_seen)
  );

  content_length_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .max_length (max_length),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .msg_byte   (msg_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .status     (status),
    .length     (length),
    .header_seen(header_seen),
    .mismatches (mismatches),
    .pending    (pending),
    .verdicts   (verdicts)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run in case the block hangs
  initial begin
    #2_000_000;
    $display("sip_content_length_parser regression: fail");
    $finish;
  end

  // Stall the result channel at random, per the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Append one byte to the message being built
  function automatic void put_byte(input logic [7:0] c);
    msg_q.insert(msg_q.size(), c);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0:       c = CH_CR;
      1:       c = CH_LF;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Mostly nothing, sometimes a blank or a lone CR or LF
  function automatic void put_pad();
    int n;
    n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       put_byte(CH_SP);
        1:       put_byte(CH_TAB);
        2:       put_byte(CH_LF);
        default: put_byte(CH_CR);
      endcase
    end
  endfunction

  function automatic void put_key();
    string      k;
    logic [7:0] c;
    case ($urandom_range(0, 9)) inside
      0, 1, 2, 3: k = "content-length";
      4, 5, 6:    k = "l";
      7: begin
        case ($urandom_range(0, 4))
          0:       k = "content-lengt";
          1:       k = "content-lengthh";
          2:       k = "ll";
          3:       k = "l l";
          default: k = "content length";
        endcase
      end
      8:       k = $urandom_range(0, 1) ? "via" : "x-l";
      default: k = "";
    endcase
    put_pad();
    for (int i = 0; i < k.len(); i++) begin
      c = k[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      put_byte(c);
    end
    put_pad();
  endfunction

  function automatic void put_value();
    int v;
    put_pad();
    case ($urandom_range(0, 9)) inside
      0, 1, 2, 3, 4, 5: begin
        case ($urandom_range(0, 3))
          0:       v = 0;
          1:       v = cur_limit;
          2:       v = $urandom_range(0, 999);
          default: v = $urandom_range(0, cur_limit);
        endcase
        if ($urandom_range(0, 7) == 0) put_text("0");
        put_text($sformatf("%0d", v));
      end
      6: begin
        v = $urandom_range(0, 1) ? cur_limit + 1 : cur_limit + $urandom_range(1, 9000000);
        put_text($sformatf("%0d", v));
      end
      7: ;
      8: begin
        case ($urandom_range(0, 3))
          0: put_text("12a");
          1: begin
            put_text("1");
            put_byte(CH_SP);
            put_text("2");
          end
          2:       put_text("-5");
          default: put_text("+7");
        endcase
      end
      default: repeat ($urandom_range(1, 3)) put_byte(noise_byte());
    endcase
    put_pad();
  endfunction

  function automatic void put_header(input logic terminate);
    put_key();
    if ($urandom_range(0, 9) != 0) put_byte(":");
    put_value();
    if (terminate) put_crlf();
  endfunction

  // Mostly well-formed headers with random content, some noise
  function automatic void build_message();
    int n_hdr;
    int ending;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) put_byte(noise_byte());
    end else begin
      ending = $urandom_range(0, 9);
      if ($urandom_range(0, 2) == 0) begin
        put_text("OPTIONS x");
        put_crlf();
      end
      n_hdr = $urandom_range(0, 3);
      for (int i = 0; i < n_hdr; i++) put_header(!(i == n_hdr - 1 && ending inside {6, 7}));
      case (ending) inside
        0, 1, 2, 3, 4, 5: begin
          put_crlf();
          repeat ($urandom_range(0, 4)) put_byte(noise_byte());
        end
        6, 7:    ;
        8:       put_byte(CH_CR);
        default: repeat ($urandom_range(1, 3)) put_byte(noise_byte());
      endcase
    end
    if (msg_q.size() == 0) put_byte(noise_byte());
  endfunction

  // Send the queued message, last_byte on its final beat
  task automatic send_message();
    foreach (msg_q[i]) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid  <= 1'b1;
      msg_byte  <= msg_q[i];
      last_byte <= (i == msg_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    bytes_sent += msg_q.size();
    msgs_sent++;
    msg_q.delete();
  endtask

  // Drop valid, wait until every verdict is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    cfg_valid  <= 1'b1;
    max_length <= CFG_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  task automatic run_directed();
    // long key, value at the reset limit, blank line ends the header section
    put_text("Content-Length: 16384");
    put_crlf();
    put_crlf();
    send_message();
    // single bytes at both extremes, no header
    put_byte(8'hff);
    send_message();
    put_byte(8'h00);
    send_message();
    // compact key, held CR on the last byte
    put_text("L:7");
    put_byte(CH_CR);
    send_message();
    // one over the limit
    put_text("l:16385");
    send_message();
    // empty value
    put_text("l:");
    send_message();
    // non-digit in value, and a digit after trailing blank
    put_text("l:1a");
    send_message();
    put_text("l:5 6");
    send_message();
    // duplicate header keeps the first value
    put_text("l:1");
    put_crlf();
    put_text("l:2");
    send_message();
    // lone LF trimmed from the key, lone CR trimmed from the value
    put_text("l");
    put_byte(CH_LF);
    put_text(":");
    put_byte(CH_CR);
    put_text("5");
    send_message();
    // header after the blank line is body
    put_crlf();
    put_crlf();
    put_text("l:3");
    send_message();
  endtask

  initial begin
    int lim;
    int phase_bytes, phase_msgs;
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    max_length <= '0;
    in_valid   <= 1'b0;
    msg_byte   <= '0;
    last_byte  <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    cur_limit     = int'(MAX_LENGTH_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p) inside
        0, 6:    lim = MIN_LIMIT;
        1, 5:    lim = MAX_LIMIT;
        2:       lim = int'(MAX_LENGTH_RESET);
        4:       lim = 99;
        default: lim = $urandom_range(MIN_LIMIT, MAX_LIMIT);
      endcase
      write_limit(lim);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = IDLE_HEAVY;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = IDLE_HEAVY;
        end
        default: begin
          send_idle_pct = IDLE_LIGHT;
          stall_pct     = IDLE_LIGHT;
        end
      endcase
      phase_bytes = bytes_sent;
      phase_msgs  = msgs_sent;
      while (bytes_sent - phase_bytes < PHASE_BYTES || msgs_sent - phase_msgs < PHASE_MSGS) begin
        build_message();
        send_message();
      end
    end

    drain();
    $display("Covered %0d messages (%0d bytes), %0d verdicts checked, %0d limit writes.",
             msgs_sent, bytes_sent, verdicts, limit_writes);
    $display("Idle modes: none, sender 83%%, receiver 83%%, both 17%%.");
    if (mismatches == 0 && pending == 0) begin
      $display("sip_content_length_parser regression: pass");
    end else begin
      $display("sip_content_length_parser regression: fail");
    end
    $finish;
  end

endmodule

FILE: sip_content_length_parser.f
src/clp_pkg.sv
src/clp_front.sv
src/clp_queue.sv
src/clp_back.sv
src/sip_content_length_parser.sv
tb/content_length_checker.sv
tb/tb_sip_content_length_parser.sv
